// ===== sv/pdv_pkg.sv =====
// ----------------------------------------------------------------------------
// pdv_pkg: shared constants and types of the posting delta varint encoder
// Default widths, varint digit size, register map and compare flags.
// ----------------------------------------------------------------------------
package pdv_pkg;

  localparam int unsigned FILE_ID_BITS_DEF = 40;
  localparam int unsigned TRIGRAM_BITS_DEF = 24;
  localparam int unsigned OFFSET_BITS_DEF  = 48;
  localparam int unsigned OFFSET_MAX_BITS  = 64;
  localparam int unsigned LIST_OFFSET_BITS = 48;

  localparam int unsigned DIGIT_BITS = 7;
  localparam int unsigned MAX_BYTES  = 6;

  localparam int unsigned CFG_ADDR_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 32;

  localparam logic [CFG_DATA_BITS-1:0] BASE_OFFSET_RESET = 32'd16;
  localparam logic                     REG_BASE_OFFSET   = 1'b0;

  typedef struct packed {
    logic tri_lt;
    logic tri_eq;
    logic fid_lt;
    logic fid_eq;
  } pdv_cmp_t;

endpackage

// ===== sv/pdv_in_if.sv =====
// ----------------------------------------------------------------------------
// pdv_in_if: input channel of the posting delta varint encoder
// Carries one (action, trigram, file id) beat under valid/ready.
// ----------------------------------------------------------------------------
interface pdv_in_if #(
  parameter int unsigned TRIGRAM_BITS = pdv_pkg::TRIGRAM_BITS_DEF,
  parameter int unsigned FILE_ID_BITS = pdv_pkg::FILE_ID_BITS_DEF
) ();
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic [TRIGRAM_BITS-1:0] trigram;
  logic [FILE_ID_BITS-1:0] file_id;

  modport source (output valid, output action, output trigram, output file_id, input ready);
  modport sink   (input valid, input action, input trigram, input file_id, output ready);
endinterface

// ===== sv/pdv_out_if.sv =====
// ----------------------------------------------------------------------------
// pdv_out_if: result channel of the posting delta varint encoder
// Carries one encoded byte, list start mark, finish or error beat.
// ----------------------------------------------------------------------------
interface pdv_out_if #(
  parameter int unsigned TRIGRAM_BITS = pdv_pkg::TRIGRAM_BITS_DEF
) ();
  logic                                  valid;
  logic                                  ready;
  logic [7:0]                            byte_value;
  logic                                  byte_valid;
  logic                                  list_start;
  logic [TRIGRAM_BITS-1:0]               list_trigram;
  logic [pdv_pkg::LIST_OFFSET_BITS-1:0]  list_offset;
  logic                                  done_res;
  logic                                  order_error;
  logic                                  last;

  modport source (output valid, output byte_value, output byte_valid, output list_start,
                  output list_trigram, output list_offset, output done_res,
                  output order_error, output last, input ready);
  modport sink   (input valid, input byte_value, input byte_valid, input list_start,
                  input list_trigram, input list_offset, input done_res,
                  input order_error, input last, output ready);
endinterface

// ===== sv/pdv_serial_cmp.sv =====
// ----------------------------------------------------------------------------
// pdv_serial_cmp: digit-serial gap subtractor and order comparator
// Shifts file ids and trigrams through 7-bit digits, LSB first, forming
// file_id - previous - 1 and the ordering flags of both keys.
// ----------------------------------------------------------------------------
module pdv_serial_cmp #(
  parameter int unsigned FILE_ID_BITS = pdv_pkg::FILE_ID_BITS_DEF,
  parameter int unsigned TRIGRAM_BITS = pdv_pkg::TRIGRAM_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [FILE_ID_BITS-1:0] fid_i,
  input  logic [FILE_ID_BITS-1:0] prev_fid_i,
  input  logic [TRIGRAM_BITS-1:0] tri_i,
  input  logic [TRIGRAM_BITS-1:0] cur_tri_i,
  output logic                    done_o,
  output logic [FILE_ID_BITS-1:0] diff_o,
  output pdv_pkg::pdv_cmp_t       cmp_o
);
  import pdv_pkg::*;

  localparam int unsigned WideBits  = (FILE_ID_BITS > TRIGRAM_BITS) ? FILE_ID_BITS
                                                                    : TRIGRAM_BITS;
  localparam int unsigned NumDigits = (WideBits + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int unsigned SerBits   = NumDigits * DIGIT_BITS;
  localparam int unsigned CntBits   = $clog2(NumDigits);
  localparam logic [CntBits-1:0] LastDigit = CntBits'(NumDigits - 1);

  logic [SerBits-1:0]    fa_q, fb_q, ta_q, tb_q, diff_q;
  logic                  fid_bor_q, fid_ne_q, tri_bor_q, tri_ne_q;
  logic                  busy_q, done_q;
  logic [CntBits-1:0]    cnt_q;
  logic [DIGIT_BITS:0]   fid_sub, tri_sub;

  always_comb begin
    fid_sub = {1'b0, fa_q[DIGIT_BITS-1:0]} - {1'b0, fb_q[DIGIT_BITS-1:0]}
              - {{DIGIT_BITS{1'b0}}, fid_bor_q};
    tri_sub = {1'b0, ta_q[DIGIT_BITS-1:0]} - {1'b0, tb_q[DIGIT_BITS-1:0]}
              - {{DIGIT_BITS{1'b0}}, tri_bor_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      done_q    <= 1'b0;
      cnt_q     <= '0;
      fid_bor_q <= 1'b0;
      fid_ne_q  <= 1'b0;
      tri_bor_q <= 1'b0;
      tri_ne_q  <= 1'b0;
      fa_q      <= '0;
      fb_q      <= '0;
      ta_q      <= '0;
      tb_q      <= '0;
      diff_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        fa_q      <= SerBits'(fid_i);
        fb_q      <= SerBits'(prev_fid_i);
        ta_q      <= SerBits'(tri_i);
        tb_q      <= SerBits'(cur_tri_i);
        fid_bor_q <= 1'b1;
        fid_ne_q  <= 1'b0;
        tri_bor_q <= 1'b0;
        tri_ne_q  <= 1'b0;
        cnt_q     <= '0;
        busy_q    <= 1'b1;
      end else if (busy_q) begin
        fa_q      <= fa_q >> DIGIT_BITS;
        fb_q      <= fb_q >> DIGIT_BITS;
        ta_q      <= ta_q >> DIGIT_BITS;
        tb_q      <= tb_q >> DIGIT_BITS;
        diff_q    <= {fid_sub[DIGIT_BITS-1:0], diff_q[SerBits-1:DIGIT_BITS]};
        fid_bor_q <= fid_sub[DIGIT_BITS];
        tri_bor_q <= tri_sub[DIGIT_BITS];
        fid_ne_q  <= fid_ne_q | (fa_q[DIGIT_BITS-1:0] != fb_q[DIGIT_BITS-1:0]);
        tri_ne_q  <= tri_ne_q | (ta_q[DIGIT_BITS-1:0] != tb_q[DIGIT_BITS-1:0]);
        cnt_q     <= cnt_q + CntBits'(1);
        if (cnt_q == LastDigit) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o       = done_q;
  assign diff_o       = diff_q[FILE_ID_BITS-1:0];
  assign cmp_o.tri_lt = tri_bor_q;
  assign cmp_o.tri_eq = !tri_ne_q;
  assign cmp_o.fid_lt = fid_bor_q & fid_ne_q;
  assign cmp_o.fid_eq = !fid_ne_q;

endmodule

// ===== sv/posting_delta_varint_encoder.sv =====
// ----------------------------------------------------------------------------
// posting_delta_varint_encoder: delta varint posting list encoder
// Flow: an accepted pair is compared digit-serially in S_CALC, judged in S_DECIDE
// and emitted one byte per beat in S_EMIT; an order error beat leaves from S_DECIDE.
// Throughput: one item at a time, input is ready only in S_IDLE; each byte, error and
// finish beat waits for a free result slot, so result stalls hold the flow.
// Reset: state idle, base_offset = 16, byte offset loaded from base_offset.
// ----------------------------------------------------------------------------
module posting_delta_varint_encoder #(
  parameter int unsigned FILE_ID_BITS = pdv_pkg::FILE_ID_BITS_DEF,
  parameter int unsigned TRIGRAM_BITS = pdv_pkg::TRIGRAM_BITS_DEF,
  parameter int unsigned OFFSET_BITS  = pdv_pkg::OFFSET_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pdv_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [pdv_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [pdv_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                               pready,
  pdv_in_if.sink                             in_if,
  pdv_out_if.source                          out_if
);
  import pdv_pkg::*;

  localparam int unsigned ByteCntBits = $clog2(MAX_BYTES);
  localparam logic [ByteCntBits-1:0] LastByte = ByteCntBits'(MAX_BYTES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_DECIDE,
    S_EMIT,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [7:0]                  byte_value;
    logic                        byte_valid;
    logic                        list_start;
    logic [TRIGRAM_BITS-1:0]     list_trigram;
    logic [LIST_OFFSET_BITS-1:0] list_offset;
    logic                        done_res;
    logic                        order_error;
    logic                        last;
  } beat_t;

  state_e                   state_q;
  logic [CFG_DATA_BITS-1:0] base_offset_q;
  logic [OFFSET_BITS-1:0]   byte_offset_q;
  logic [TRIGRAM_BITS-1:0]  cur_tri_q, tri_q;
  logic [FILE_ID_BITS-1:0]  prev_fid_q, fid_q, gap_q;
  logic                     prev_valid_q, fresh_q;
  logic [ByteCntBits-1:0]   cnt_q;
  logic                     out_valid_q;
  beat_t                    out_q;

  logic                     in_accept, calc_start, slot_free, cfg_write;
  logic                     calc_done;
  logic [FILE_ID_BITS-1:0]  diff;
  pdv_cmp_t                 cmp;
  logic                     fresh, order_err, repeat_pair, more, last_byte;
  logic [OFFSET_MAX_BITS-1:0] ofs_wide;
  beat_t                    err_beat, byte_beat, done_beat;

  pdv_serial_cmp #(
    .FILE_ID_BITS(FILE_ID_BITS),
    .TRIGRAM_BITS(TRIGRAM_BITS)
  ) u_serial_cmp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (calc_start),
    .fid_i      (in_if.file_id),
    .prev_fid_i (prev_fid_q),
    .tri_i      (in_if.trigram),
    .cur_tri_i  (cur_tri_q),
    .done_o     (calc_done),
    .diff_o     (diff),
    .cmp_o      (cmp)
  );

  assign in_if.ready = (state_q == S_IDLE);
  assign in_accept   = in_if.valid & in_if.ready;
  assign calc_start  = in_accept & !in_if.action;
  assign slot_free   = !out_valid_q || out_if.ready;
  assign cfg_write   = psel & penable & pwrite & pready
                       & (paddr[CFG_ADDR_BITS-1] == REG_BASE_OFFSET);
  assign pready      = 1'b1;
  assign prdata      = base_offset_q;

  always_comb begin
    fresh       = !prev_valid_q || !cmp.tri_eq;
    order_err   = prev_valid_q && (cmp.tri_lt || (cmp.tri_eq && cmp.fid_lt));
    repeat_pair = !fresh && cmp.fid_eq;
    more        = |gap_q[FILE_ID_BITS-1:DIGIT_BITS];
    last_byte   = !more || (cnt_q == LastByte);
    ofs_wide    = OFFSET_MAX_BITS'(byte_offset_q);

    err_beat             = '0;
    err_beat.order_error = 1'b1;
    err_beat.last        = 1'b1;

    done_beat             = '0;
    done_beat.list_offset = ofs_wide[LIST_OFFSET_BITS-1:0];
    done_beat.done_res    = 1'b1;
    done_beat.last        = 1'b1;

    byte_beat            = '0;
    byte_beat.byte_value = {more & (cnt_q != LastByte), gap_q[DIGIT_BITS-1:0]};
    byte_beat.byte_valid = 1'b1;
    byte_beat.last       = last_byte;
    if (fresh_q) begin
      byte_beat.list_start   = 1'b1;
      byte_beat.list_trigram = tri_q;
      byte_beat.list_offset  = ofs_wide[LIST_OFFSET_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      base_offset_q <= BASE_OFFSET_RESET;
      byte_offset_q <= OFFSET_BITS'(BASE_OFFSET_RESET);
      cur_tri_q     <= '0;
      prev_fid_q    <= '0;
      prev_valid_q  <= 1'b0;
      tri_q         <= '0;
      fid_q         <= '0;
      gap_q         <= '0;
      fresh_q       <= 1'b0;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_write) begin
        base_offset_q <= pwdata;
        if (!prev_valid_q) begin
          byte_offset_q <= OFFSET_BITS'(pwdata);
        end
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            tri_q   <= in_if.trigram;
            fid_q   <= in_if.file_id;
            state_q <= in_if.action ? S_FINISH : S_CALC;
          end
        end
        S_CALC: begin
          if (calc_done) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          priority if (order_err) begin
            if (slot_free) begin
              out_q       <= err_beat;
              out_valid_q <= 1'b1;
              state_q     <= S_IDLE;
            end
          end else if (repeat_pair) begin
            state_q <= S_IDLE;
          end else begin
            gap_q   <= fresh ? fid_q : diff;
            fresh_q <= fresh;
            cnt_q   <= '0;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_q         <= byte_beat;
            out_valid_q   <= 1'b1;
            byte_offset_q <= byte_offset_q + OFFSET_BITS'(1);
            gap_q         <= gap_q >> DIGIT_BITS;
            cnt_q         <= cnt_q + ByteCntBits'(1);
            fresh_q       <= 1'b0;
            if (last_byte) begin
              cur_tri_q    <= tri_q;
              prev_fid_q   <= fid_q;
              prev_valid_q <= 1'b1;
              state_q      <= S_IDLE;
            end
          end
        end
        S_FINISH: begin
          if (slot_free) begin
            out_q         <= done_beat;
            out_valid_q   <= 1'b1;
            cur_tri_q     <= '0;
            prev_fid_q    <= '0;
            prev_valid_q  <= 1'b0;
            byte_offset_q <= OFFSET_BITS'(base_offset_q);
            state_q       <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.byte_value   = out_q.byte_value;
  assign out_if.byte_valid   = out_q.byte_valid;
  assign out_if.list_start   = out_q.list_start;
  assign out_if.list_trigram = out_q.list_trigram;
  assign out_if.list_offset  = out_q.list_offset;
  assign out_if.done_res     = out_q.done_res;
  assign out_if.order_error  = out_q.order_error;
  assign out_if.last         = out_q.last;

endmodule
